[rtl/core/ghwr_pkg.sv]
// shared types and constants for the half-weighting restriction block
package ghwr_pkg;

  localparam int SampleBits = 32;
  localparam int CoordBits = 9;
  localparam int CfgIndexBits = 2;
  localparam int CfgDataBits = 16;

  localparam int FineColsBits = 11;
  localparam int FineRowsBits = 16;
  localparam int CoarseBits = 10;

  localparam logic [FineColsBits-1:0] FineColsReset = 11'd1024;
  localparam logic [FineRowsBits-1:0] FineRowsReset = 16'd1024;
  localparam logic [CoarseBits-1:0] CoarseColsReset = 10'd512;
  localparam logic [CoarseBits-1:0] CoarseRowsReset = 10'd512;
  localparam logic [CoordBits-1:0] CoordMax = 9'd511;

  typedef enum logic [CfgIndexBits-1:0] {
    CFG_FINE_COLS = 2'd0,
    CFG_FINE_ROWS = 2'd1,
    CFG_COARSE_COLS = 2'd2,
    CFG_COARSE_ROWS = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic first_of_grid;
  } item_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] coarse_value;
    logic [CoordBits-1:0] coarse_row;
    logic [CoordBits-1:0] coarse_col;
    logic last_of_grid;
  } result_t;

endpackage

[rtl/core/ghwr_line_ram.sv]
// line buffer memory, one write and one registered read per cycle
module ghwr_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/grid_half_weight_restrict.sv]
// Streaming 2-D half-weighting restriction: fine samples arrive in raster order, one
// transaction per cycle, and each coarse interior point is formed once the fine sample
// below its centre is taken: the line buffer reads and that sample are registered in the
// window stage and their sum goes into the output register. Two line memories, each with
// one write and one read per cycle, hold the two fine rows above the current one; a read
// that hits the entry written in the same cycle is forwarded, so the block sustains one
// sample per cycle and only stalls when the output register is full and not taken.
module grid_half_weight_restrict #(
  parameter int MAX_FINE_COLS = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  ghwr_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output ghwr_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  ghwr_pkg::cfg_index_t                cfg_index,
  input  logic [ghwr_pkg::CfgDataBits-1:0]    cfg_data
);
  import ghwr_pkg::*;

  localparam int ColBits = $clog2(MAX_FINE_COLS);
  localparam int CntBits = ColBits + 1;
  localparam int SumBits = SampleBits + 3;
  localparam logic [31:0] MaxCols = 32'(MAX_FINE_COLS);

  // configuration
  logic [FineColsBits-1:0] fine_cols;
  logic [FineRowsBits-1:0] fine_rows;
  logic [CoarseBits-1:0] coarse_cols;
  logic [CoarseBits-1:0] coarse_rows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fine_cols <= FineColsReset;
      fine_rows <= FineRowsReset;
      coarse_cols <= CoarseColsReset;
      coarse_rows <= CoarseRowsReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FINE_COLS: fine_cols <= cfg_data[FineColsBits-1:0];
        CFG_FINE_ROWS: fine_rows <= cfg_data[FineRowsBits-1:0];
        CFG_COARSE_COLS: coarse_cols <= cfg_data[CoarseBits-1:0];
        CFG_COARSE_ROWS: coarse_rows <= cfg_data[CoarseBits-1:0];
      endcase
    end
  end

  // effective column count and coarse limits
  logic [31:0] fc_wide;
  logic [CntBits-1:0] cols;
  logic [15:0] ci_lim_cfg, ci_lim_fine, cj_lim_cfg, cj_lim_fine;
  logic [15:0] ci_lim, cj_lim;
  logic [CoordBits-1:0] ci_max, cj_max;

  always_comb begin
    fc_wide = 32'(fine_cols);
    if (fc_wide == 32'd0) begin
      cols = CntBits'(1);
    end else if (fc_wide > MaxCols) begin
      cols = CntBits'(MaxCols);
    end else begin
      cols = CntBits'(fc_wide);
    end
    ci_lim_cfg = (coarse_rows < 10'd3) ? 16'd0 : 16'(coarse_rows - 10'd2);
    cj_lim_cfg = (coarse_cols < 10'd3) ? 16'd0 : 16'(coarse_cols - 10'd2);
    ci_lim_fine = (fine_rows < 16'd4) ? 16'd0 : ((fine_rows - 16'd2) >> 1);
    cj_lim_fine = (32'(cols) < 32'd4) ? 16'd0 : 16'((32'(cols) - 32'd2) >> 1);
    ci_lim = (ci_lim_cfg < ci_lim_fine) ? ci_lim_cfg : ci_lim_fine;
    cj_lim = (cj_lim_cfg < cj_lim_fine) ? cj_lim_cfg : cj_lim_fine;
    ci_max = (ci_lim > 16'(CoordMax)) ? CoordMax : ci_lim[CoordBits-1:0];
    cj_max = (cj_lim > 16'(CoordMax)) ? CoordMax : cj_lim[CoordBits-1:0];
  end

  // pipeline control
  logic accept;
  logic b_valid;
  logic b_go;

  assign b_go = b_valid && (!result_valid || result_ready);
  assign item_ready = !b_valid || b_go;
  assign accept = item_valid && item_ready;

  // position stage
  logic [ColBits-1:0] col_pos, col_pos_next;
  logic [15:0] row_pos, row_pos_next;
  logic [ColBits-1:0] c_a;
  logic [15:0] r_a;
  logic [CntBits-1:0] c1_a;
  logic last_col_a;
  logic [14:0] ci_a;
  logic [ColBits-2:0] cj_a;
  logic prod_a, last_a;

  always_comb begin
    if (item.first_of_grid || ({1'b0, col_pos} >= cols)) begin
      c_a = '0;
    end else begin
      c_a = col_pos;
    end
    r_a = item.first_of_grid ? 16'd0 : row_pos;
    c1_a = {1'b0, c_a} + CntBits'(1);
    last_col_a = (c1_a >= cols);
    col_pos_next = last_col_a ? '0 : c1_a[ColBits-1:0];
    if (!last_col_a) begin
      row_pos_next = r_a;
    end else if ((17'(r_a) + 17'd1 >= 17'(fine_rows)) || (r_a == 16'hFFFF)) begin
      row_pos_next = 16'd0;
    end else begin
      row_pos_next = r_a + 16'd1;
    end
    ci_a = r_a[15:1];
    cj_a = c_a[ColBits-1:1];
    prod_a = r_a[0] && !c_a[0] && (ci_a != 15'd0) && (16'(ci_a) <= 16'(ci_max))
             && (cj_a != '0) && (16'(cj_a) <= 16'(cj_max));
    last_a = (16'(ci_a) == 16'(ci_max)) && (16'(cj_a) == 16'(cj_max));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

  // line buffers
  logic [SampleBits-1:0] mid_q, up_q;
  logic [ColBits-1:0] b_c;
  logic signed [SampleBits-1:0] b_s;
  logic signed [SampleBits-1:0] w0, w1, w2;

  ghwr_line_ram #(.DEPTH(MAX_FINE_COLS), .WIDTH(SampleBits)) u_middle (
    .clk   (clk),
    .we    (b_go),
    .waddr (b_c),
    .wdata (b_s),
    .re    (accept),
    .raddr (c1_a[ColBits-1:0]),
    .rdata (mid_q)
  );

  ghwr_line_ram #(.DEPTH(MAX_FINE_COLS), .WIDTH(SampleBits)) u_upper (
    .clk   (clk),
    .we    (b_go),
    .waddr (b_c),
    .wdata (w1),
    .re    (accept),
    .raddr (c_a),
    .rdata (up_q)
  );

  // window stage
  logic b_c_zero, b_w2_ok, b_prod, b_last;
  logic [CoordBits-1:0] b_row, b_col;
  logic fwd_mid, fwd_up;
  logic signed [SampleBits-1:0] fwd_mid_val, fwd_up_val;
  logic signed [SampleBits-1:0] mid0, win1, win2;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_c <= c_a;
      b_s <= item.sample;
      b_c_zero <= (c_a == '0);
      b_w2_ok <= !last_col_a;
      b_prod <= prod_a;
      b_last <= last_a;
      b_row <= ci_a[CoordBits-1:0];
      b_col <= CoordBits'(cj_a);
      fwd_mid <= b_valid && (b_c == c1_a[ColBits-1:0]);
      fwd_up <= b_valid && (b_c == c_a);
      fwd_mid_val <= b_s;
      fwd_up_val <= w1;
    end
  end

  logic signed [SampleBits-1:0] mid_rd, up_rd;
  logic signed [SumBits-1:0] total;

  always_comb begin
    mid_rd = fwd_mid ? fwd_mid_val : $signed(mid_q);
    up_rd = fwd_up ? fwd_up_val : $signed(up_q);
    w0 = b_c_zero ? '0 : win1;
    w1 = b_c_zero ? mid0 : win2;
    w2 = b_w2_ok ? mid_rd : '0;
    total = (SumBits'(w1) <<< 2) + SumBits'(w0) + SumBits'(w2) + SumBits'(up_rd)
            + SumBits'(b_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win1 <= '0;
      win2 <= '0;
    end else if (b_go) begin
      win1 <= w1;
      win2 <= w2;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_c_zero) begin
      mid0 <= b_s;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_go && b_prod) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_prod) begin
      result.coarse_value <= SampleBits'(total >>> 3);
      result.coarse_row <= b_row;
      result.coarse_col <= b_col;
      result.last_of_grid <= b_last;
    end
  end

endmodule

[rtl/core/ghwr_checker.sv]
// port-level checks for the half-weighting restriction block
module ghwr_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   item_ready,
  input logic                   result_valid,
  input logic                   result_ready,
  input ghwr_pkg::result_t      result
);
  import ghwr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result present after reset");

  a_interior: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.coarse_row != '0) && (result.coarse_col != '0))
    else $error("boundary point produced");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("input stalled without output backpressure");

endmodule

bind grid_half_weight_restrict ghwr_checker u_ghwr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
